// ===== hw/rtl/ffa_pkg.sv =====
`default_nettype none
package ffa_pkg;

  // default arena geometry
  localparam int ARENA_UNITS = 16384;
  localparam int UNIT_BYTES  = 16;

  // fixed field widths of the channels
  localparam int REQ_W  = 19;
  localparam int ADDR_W = 14;

  // item codes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_A_MUL,
    S_A_INIT,
    S_A_RROV,
    S_A_NEXT,
    S_A_CHK,
    S_A_SPLIT,
    S_F_CHK,
    S_F_WALK,
    S_F_GETNX,
    S_F_RNX,
    S_F_RBLK,
    S_F_RP,
    S_F_MRG,
    S_F_MRG2,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ffa_if.sv =====
`default_nettype none
// request channel
interface ffa_in_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [ffa_pkg::REQ_W-1:0]    request_bytes;
  logic [ffa_pkg::ADDR_W-1:0]   free_address;

  modport source (output valid, mode, request_bytes, free_address, input ready);
  modport sink   (input valid, mode, request_bytes, free_address, output ready);
endinterface

// result channel
interface ffa_out_if;
  logic                         valid;
  logic                         ready;
  logic                         ok;
  logic [ffa_pkg::ADDR_W-1:0]   block_address;

  modport source (output valid, ok, block_address, input ready);
  modport sink   (input valid, ok, block_address, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/first_fit_free_list_allocator.sv =====
// First-fit allocator over an arena of ARENA_UNITS header-sized units.
// Request channel in_ch: mode 0 allocates request_bytes, mode 1 frees the
// block whose data starts at unit free_address. Result channel out_ch:
// one transfer per request, ok and block_address (data start unit, zero on
// failure and for frees). A transfer completes when valid and ready are high.
// Items are handled one at a time. The free list lives in two header
// memories (size and link) with registered reads; the list walk visits one
// free block per cycle. A new request is taken as soon as the sequencer
// is idle, while an earlier result may still wait in the output register;
// a stalled receiver only holds the sequencer in its final state until that
// register frees up. Reset clears the rover and the list flags and needs
// no memory sweep: the arena is set up as one free block on the first
// allocation.
`default_nettype none
module first_fit_free_list_allocator #(
  parameter int ARENA_UNITS = ffa_pkg::ARENA_UNITS,
  parameter int UNIT_BYTES  = ffa_pkg::UNIT_BYTES
) (
  input  wire         clk,
  input  wire         rst_n,
  ffa_in_if.sink      in_ch,
  ffa_out_if.source   out_ch
);

  localparam int AW  = $clog2(ARENA_UNITS);
  localparam int SW  = $clog2(ARENA_UNITS + 1);
  localparam int CW  = ((SW > 20) ? SW : 20) + 1;
  localparam int BW  = ffa_pkg::REQ_W + 1;
  localparam int KSH = BW + $clog2(UNIT_BYTES);
  localparam int RW  = KSH - $clog2(UNIT_BYTES) + 2;
  localparam longint RECIP = ((64'd1 << KSH) + UNIT_BYTES - 1) / UNIT_BYTES;
  localparam int STW = $clog2(ARENA_UNITS + 2);
  localparam int PW  = BW + RW;

  // header memories
  logic [SW-1:0] size_mem [ARENA_UNITS];
  logic [AW-1:0] next_mem [ARENA_UNITS];

  logic [AW-1:0] rd_addr;
  logic [SW-1:0] rd_size_r;
  logic [AW-1:0] rd_next_r;
  logic          sz_we, nx_we;
  logic [AW-1:0] sz_wa, nx_wa;
  logic [SW-1:0] sz_wd;
  logic [AW-1:0] nx_wd;

  ffa_pkg::state_t state_r, state_nxt;
  logic                      mode_r, mode_nxt;
  logic [ffa_pkg::REQ_W-1:0] bytes_r, bytes_nxt;
  logic [ffa_pkg::ADDR_W-1:0] faddr_r, faddr_nxt;
  logic [PW-1:0]  prod_r, prod_nxt;
  logic [CW-1:0]  n_r, n_nxt;
  logic [AW-1:0]  prev_r, prev_nxt, p_r, p_nxt, blk_r, blk_nxt, nx_r, nx_nxt;
  logic [AW-1:0]  tail_r, tail_nxt, nxnext_r, nxnext_nxt, nbn_r, nbn_nxt;
  logic [SW-1:0]  nxsz_r, nxsz_nxt, blksz_r, blksz_nxt, nbs_r, nbs_nxt;
  logic [SW-1:0]  psz_r, psz_nxt;
  logic           pmrg_r, pmrg_nxt;
  logic [STW-1:0] steps_r, steps_nxt;
  logic [AW-1:0]  rover_r, rover_nxt;
  logic           started_r, started_nxt, empty_r, empty_nxt;
  logic           res_ok_r, res_ok_nxt;
  logic [ffa_pkg::ADDR_W-1:0] res_addr_r, res_addr_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_ok_r, out_ok_nxt;
  logic [ffa_pkg::ADDR_W-1:0] out_addr_r, out_addr_nxt;

  // scratch values
  logic [BW-1:0]  bx;
  logic [CW-1:0]  szx, tmp, sumx;
  logic [AW-1:0]  wnx;
  logic           brk;

  // memory ports
  always_ff @(posedge clk) begin
    if (sz_we) size_mem[sz_wa] <= sz_wd;
    if (nx_we) next_mem[nx_wa] <= nx_wd;
    rd_size_r <= size_mem[rd_addr];
    rd_next_r <= next_mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffa_pkg::S_IDLE;
      rover_r     <= '0;
      started_r   <= 1'b0;
      empty_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rover_r     <= rover_nxt;
      started_r   <= started_nxt;
      empty_r     <= empty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    bytes_r    <= bytes_nxt;
    faddr_r    <= faddr_nxt;
    prod_r     <= prod_nxt;
    n_r        <= n_nxt;
    prev_r     <= prev_nxt;
    p_r        <= p_nxt;
    blk_r      <= blk_nxt;
    nx_r       <= nx_nxt;
    tail_r     <= tail_nxt;
    nxnext_r   <= nxnext_nxt;
    nbn_r      <= nbn_nxt;
    nxsz_r     <= nxsz_nxt;
    blksz_r    <= blksz_nxt;
    nbs_r      <= nbs_nxt;
    psz_r      <= psz_nxt;
    pmrg_r     <= pmrg_nxt;
    steps_r    <= steps_nxt;
    res_ok_r   <= res_ok_nxt;
    res_addr_r <= res_addr_nxt;
    out_ok_r   <= out_ok_nxt;
    out_addr_r <= out_addr_nxt;
  end

  assign in_ch.ready          = (state_r == ffa_pkg::S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.ok            = out_ok_r;
  assign out_ch.block_address = out_addr_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    bytes_nxt     = bytes_r;
    faddr_nxt     = faddr_r;
    prod_nxt      = prod_r;
    n_nxt         = n_r;
    prev_nxt      = prev_r;
    p_nxt         = p_r;
    blk_nxt       = blk_r;
    nx_nxt        = nx_r;
    tail_nxt      = tail_r;
    nxnext_nxt    = nxnext_r;
    nbn_nxt       = nbn_r;
    nxsz_nxt      = nxsz_r;
    blksz_nxt     = blksz_r;
    nbs_nxt       = nbs_r;
    psz_nxt       = psz_r;
    pmrg_nxt      = pmrg_r;
    steps_nxt     = steps_r;
    rover_nxt     = rover_r;
    started_nxt   = started_r;
    empty_nxt     = empty_r;
    res_ok_nxt    = res_ok_r;
    res_addr_nxt  = res_addr_r;
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_addr_nxt  = out_addr_r;
    rd_addr       = p_r;
    sz_we = 1'b0; sz_wa = '0; sz_wd = '0;
    nx_we = 1'b0; nx_wa = '0; nx_wd = '0;
    bx    = '0;
    szx   = CW'(rd_size_r);
    tmp   = '0;
    sumx  = '0;
    wnx   = rd_next_r;
    brk   = 1'b0;

    // result register drains independently of the sequencer
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      ffa_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          mode_nxt   = in_ch.mode;
          bytes_nxt  = in_ch.request_bytes;
          faddr_nxt  = in_ch.free_address;
          res_ok_nxt = 1'b1;
          res_addr_nxt = '0;
          state_nxt  = (in_ch.mode == ffa_pkg::MODE_FREE) ? ffa_pkg::S_F_CHK
                                                          : ffa_pkg::S_A_MUL;
        end
      end

      // units = ceil(bytes / UNIT_BYTES) by reciprocal multiply
      ffa_pkg::S_A_MUL: begin
        bx = (bytes_r == '0) ? BW'(1) : BW'(bytes_r);
        bx = bx + BW'(UNIT_BYTES - 1);
        prod_nxt = PW'(bx) * PW'(RECIP);
        state_nxt = ffa_pkg::S_A_INIT;
      end

      // header count and lazy arena setup
      ffa_pkg::S_A_INIT: begin
        n_nxt = CW'(prod_r >> KSH) + CW'(1);
        if (!started_r) begin
          sz_we = 1'b1; sz_wa = '0; sz_wd = SW'(ARENA_UNITS);
          nx_we = 1'b1; nx_wa = '0; nx_wd = '0;
          rover_nxt   = '0;
          started_nxt = 1'b1;
          empty_nxt   = 1'b0;
          state_nxt   = ffa_pkg::S_A_RROV;
        end else if (empty_r) begin
          res_ok_nxt = 1'b0;
          state_nxt  = ffa_pkg::S_DONE;
        end else begin
          state_nxt = ffa_pkg::S_A_RROV;
        end
      end

      ffa_pkg::S_A_RROV: begin
        rd_addr   = rover_r;
        prev_nxt  = rover_r;
        state_nxt = ffa_pkg::S_A_NEXT;
      end

      ffa_pkg::S_A_NEXT: begin
        rd_addr   = rd_next_r;
        p_nxt     = rd_next_r;
        steps_nxt = '0;
        state_nxt = ffa_pkg::S_A_CHK;
      end

      // one free block per cycle
      ffa_pkg::S_A_CHK: begin
        if (szx >= n_r) begin
          rover_nxt = prev_r;
          if (szx == n_r) begin
            if (p_r == prev_r) begin
              empty_nxt = 1'b1;
            end else begin
              nx_we = 1'b1; nx_wa = prev_r; nx_wd = rd_next_r;
            end
            tmp = CW'(p_r) + CW'(1);
            res_addr_nxt = tmp[ffa_pkg::ADDR_W-1:0];
            state_nxt = ffa_pkg::S_DONE;
          end else begin
            sz_we = 1'b1; sz_wa = p_r; sz_wd = SW'(szx - n_r);
            tail_nxt  = AW'(CW'(p_r) + szx - n_r);
            state_nxt = ffa_pkg::S_A_SPLIT;
          end
        end else if (p_r == rover_r || steps_r == STW'(ARENA_UNITS)) begin
          res_ok_nxt = 1'b0;
          state_nxt  = ffa_pkg::S_DONE;
        end else begin
          prev_nxt  = p_r;
          p_nxt     = rd_next_r;
          rd_addr   = rd_next_r;
          steps_nxt = steps_r + STW'(1);
        end
      end

      // tail of a larger block gets its own header
      ffa_pkg::S_A_SPLIT: begin
        sz_we = 1'b1; sz_wa = tail_r; sz_wd = SW'(n_r);
        tmp = CW'(tail_r) + CW'(1);
        res_addr_nxt = tmp[ffa_pkg::ADDR_W-1:0];
        state_nxt = ffa_pkg::S_DONE;
      end

      ffa_pkg::S_F_CHK: begin
        tmp = CW'(faddr_r) - CW'(1);
        blk_nxt = tmp[AW-1:0];
        if (!started_r || faddr_r == '0 || CW'(faddr_r) > CW'(ARENA_UNITS)) begin
          state_nxt = ffa_pkg::S_DONE;
        end else if (empty_r) begin
          nx_we = 1'b1; nx_wa = tmp[AW-1:0]; nx_wd = tmp[AW-1:0];
          rover_nxt = tmp[AW-1:0];
          empty_nxt = 1'b0;
          state_nxt = ffa_pkg::S_DONE;
        end else begin
          rd_addr   = rover_r;
          p_nxt     = rover_r;
          steps_nxt = '0;
          state_nxt = ffa_pkg::S_F_WALK;
        end
      end

      // find the block after which the freed block goes
      ffa_pkg::S_F_WALK: begin
        brk = (blk_r > p_r && blk_r < wnx) ||
              (p_r >= wnx && (blk_r > p_r || blk_r < wnx));
        if (brk) begin
          nx_nxt    = wnx;
          state_nxt = ffa_pkg::S_F_RNX;
        end else begin
          p_nxt     = wnx;
          rd_addr   = wnx;
          steps_nxt = steps_r + STW'(1);
          if (steps_r == STW'(ARENA_UNITS)) state_nxt = ffa_pkg::S_F_GETNX;
        end
      end

      ffa_pkg::S_F_GETNX: begin
        nx_nxt    = rd_next_r;
        state_nxt = ffa_pkg::S_F_RNX;
      end

      ffa_pkg::S_F_RNX: begin
        rd_addr   = nx_r;
        state_nxt = ffa_pkg::S_F_RBLK;
      end

      ffa_pkg::S_F_RBLK: begin
        nxsz_nxt   = rd_size_r;
        nxnext_nxt = rd_next_r;
        rd_addr    = blk_r;
        state_nxt  = ffa_pkg::S_F_RP;
      end

      ffa_pkg::S_F_RP: begin
        blksz_nxt = rd_size_r;
        rd_addr   = p_r;
        state_nxt = ffa_pkg::S_F_MRG;
      end

      // merge with the upper neighbor
      ffa_pkg::S_F_MRG: begin
        psz_nxt = rd_size_r;
        sumx = CW'(blk_r) + CW'(blksz_r);
        if (sumx == CW'(nx_r)) begin
          nbs_nxt = SW'(CW'(blksz_r) + CW'(nxsz_r));
          nbn_nxt = nxnext_r;
        end else begin
          nbs_nxt = blksz_r;
          nbn_nxt = nx_r;
        end
        sz_we = 1'b1; sz_wa = blk_r; sz_wd = nbs_nxt;
        nx_we = 1'b1; nx_wa = blk_r; nx_wd = nbn_nxt;
        pmrg_nxt  = ((CW'(p_r) + CW'(rd_size_r)) == CW'(blk_r));
        state_nxt = ffa_pkg::S_F_MRG2;
      end

      // merge with the lower neighbor or link in
      ffa_pkg::S_F_MRG2: begin
        nx_we = 1'b1; nx_wa = p_r;
        if (pmrg_r) begin
          sz_we = 1'b1; sz_wa = p_r; sz_wd = SW'(CW'(psz_r) + CW'(nbs_r));
          nx_wd = nbn_r;
        end else begin
          nx_wd = blk_r;
        end
        rover_nxt = p_r;
        state_nxt = ffa_pkg::S_DONE;
      end

      // hand the result to the output register
      ffa_pkg::S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_addr_nxt  = res_ok_r ? res_addr_r : '0;
          state_nxt     = ffa_pkg::S_IDLE;
        end
      end

      default: state_nxt = ffa_pkg::S_IDLE;
    endcase
  end

  // checks
  a_empty_needs_list: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r |-> started_r) else $error("empty list flag without a list");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r != ffa_pkg::S_IDLE))
    else $error("request taken but sequencer idle");

  a_empty_from_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(empty_r) |-> $past(state_r == ffa_pkg::S_A_CHK))
    else $error("list emptied outside an allocation");

  a_fail_is_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ffa_pkg::S_DONE && !res_ok_r) |-> (mode_r == ffa_pkg::MODE_ALLOC))
    else $error("failure reported for a free");

endmodule
`default_nettype wire
